// ===== src/erm_pkg.sv =====
`timescale 1ns / 1ps

package erm_pkg;

  localparam int ANGLE_BITS      = 16;
  localparam int SINE_INDEX_BITS = 10;
  localparam int FRACTION_BITS   = 14;

  localparam int IN_W    = 16;
  localparam int OUT_W   = FRACTION_BITS + 2;
  localparam int PROD_W  = 2 * OUT_W;
  localparam int SUM_W   = OUT_W + 1;
  localparam int QUARTER = 1 << (SINE_INDEX_BITS - 2);
  localparam int STAGES  = 4;

  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;
  localparam logic signed [OUT_W-1:0] ONE_FX = OUT_W'(1) << FRACTION_BITS;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRACTION_BITS - 1);

  typedef logic [FRACTION_BITS:0] sine_tab_t [0:QUARTER];

  typedef struct packed {
    logic signed [IN_W-1:0] angle_x;
    logic signed [IN_W-1:0] angle_y;
    logic signed [IN_W-1:0] angle_z;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m01;
    logic signed [OUT_W-1:0] m02;
    logic signed [OUT_W-1:0] m10;
    logic signed [OUT_W-1:0] m11;
    logic signed [OUT_W-1:0] m12;
    logic signed [OUT_W-1:0] m20;
    logic signed [OUT_W-1:0] m21;
    logic signed [OUT_W-1:0] m22;
  } out_word_t;

  // Sines and cosines of the three angles
  typedef struct packed {
    logic signed [OUT_W-1:0] sx;
    logic signed [OUT_W-1:0] cx;
    logic signed [OUT_W-1:0] sy;
    logic signed [OUT_W-1:0] cy;
    logic signed [OUT_W-1:0] sz;
    logic signed [OUT_W-1:0] cz;
  } trig_t;

  // First-level products, each rounded, plus sx, cx and the negated sy
  typedef struct packed {
    logic signed [OUT_W-1:0] sx;
    logic signed [OUT_W-1:0] cx;
    logic signed [OUT_W-1:0] szsy;
    logic signed [OUT_W-1:0] czsy;
    logic signed [OUT_W-1:0] czcy;
    logic signed [OUT_W-1:0] szcy;
    logic signed [OUT_W-1:0] sxcy;
    logic signed [OUT_W-1:0] cxcy;
    logic signed [OUT_W-1:0] sxsz;
    logic signed [OUT_W-1:0] cxsz;
    logic signed [OUT_W-1:0] cxcz;
    logic signed [OUT_W-1:0] sxcz;
    logic signed [OUT_W-1:0] nsy;
  } prod_t;

  // Second-level products plus the terms that pass straight through
  typedef struct packed {
    logic signed [OUT_W-1:0] czcy;
    logic signed [OUT_W-1:0] szcy;
    logic signed [OUT_W-1:0] nsy;
    logic signed [OUT_W-1:0] sxcy;
    logic signed [OUT_W-1:0] cxcy;
    logic signed [OUT_W-1:0] sx_czsy;
    logic signed [OUT_W-1:0] cxsz;
    logic signed [OUT_W-1:0] cx_czsy;
    logic signed [OUT_W-1:0] sxsz;
    logic signed [OUT_W-1:0] sx_szsy;
    logic signed [OUT_W-1:0] cxcz;
    logic signed [OUT_W-1:0] cx_szsy;
    logic signed [OUT_W-1:0] sxcz;
  } term_t;

  // floor(a * b / 2^60) on unsigned Q60 values
  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Truncated unsigned quotient by shift and subtract, for table building
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave sine table by integer Taylor series, built at elaboration
  function automatic sine_tab_t sine_table_build();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    for (int k = 0; k <= QUARTER; k++) begin
      x = (HALF_PI_Q60 / QUARTER) * 64'(k) + ((HALF_PI_Q60 % QUARTER) * 64'(k)) / QUARTER;
      x2 = mul_q60(x, x);
      t = x;
      s = x;
      for (int i = 1; i <= 14; i++) begin
        t = udiv64(mul_q60(t, x2), 64'(2 * i) * 64'(2 * i + 1));
        if ((i % 2) == 1) begin
          s = s - t;
        end else begin
          s = s + t;
        end
      end
      r = (s + (64'd1 << (59 - FRACTION_BITS))) >> (60 - FRACTION_BITS);
      if (r > 64'(ONE_FX)) begin
        r = 64'(ONE_FX);
      end
      tab[k] = r[FRACTION_BITS:0];
    end
    tab[0] = '0;
    tab[QUARTER] = ONE_FX[FRACTION_BITS:0];
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = sine_table_build();

  // Fixed-point product, rounded half toward plus infinity
  function automatic logic signed [OUT_W-1:0] fmul(logic signed [OUT_W-1:0] a,
                                                   logic signed [OUT_W-1:0] b);
    logic signed [PROD_W-1:0] p;
    p = (PROD_W'(a) * PROD_W'(b)) + ROUND_HALF;
    p = p >>> FRACTION_BITS;
    return p[OUT_W-1:0];
  endfunction

endpackage

// ===== src/erm_trig.sv =====
`timescale 1ns / 1ps

module erm_trig (
  input  logic              clk,
  input  logic              en,
  input  erm_pkg::in_word_t word_in,
  output erm_pkg::trig_t    trig_out
);

  localparam int SIB = erm_pkg::SINE_INDEX_BITS;
  localparam int AB  = erm_pkg::ANGLE_BITS;

  erm_pkg::trig_t trig_nxt;
  erm_pkg::trig_t trig_r;

  // Top index bits of the angle; pads with zeros when the index is wider
  function automatic logic [SIB-1:0] phase_of(logic [erm_pkg::IN_W-1:0] angle);
    logic [AB+SIB-1:0] ext;
    ext = {angle[AB-1:0], {SIB{1'b0}}};
    return ext[AB+SIB-1 -: SIB];
  endfunction

  // Quarter-wave lookup with mirror and sign by quadrant
  function automatic logic signed [erm_pkg::OUT_W-1:0] sine_at(logic [SIB-1:0] idx);
    logic [1:0]                      q;
    logic [SIB-2:0]                  r;
    logic [SIB-2:0]                  addr;
    logic signed [erm_pkg::OUT_W-1:0] v;
    q = idx[SIB-1:SIB-2];
    r = {1'b0, idx[SIB-3:0]};
    addr = q[0] ? ((SIB-1)'(erm_pkg::QUARTER) - r) : r;
    v = erm_pkg::OUT_W'(erm_pkg::SINE_TAB[addr]);
    return q[1] ? -v : v;
  endfunction

  function automatic logic signed [erm_pkg::OUT_W-1:0] cosine_at(logic [SIB-1:0] idx);
    return sine_at(idx + SIB'(erm_pkg::QUARTER));
  endfunction

  // Look up all six values
  always_comb begin
    trig_nxt.sx = sine_at(phase_of(word_in.angle_x));
    trig_nxt.cx = cosine_at(phase_of(word_in.angle_x));
    trig_nxt.sy = sine_at(phase_of(word_in.angle_y));
    trig_nxt.cy = cosine_at(phase_of(word_in.angle_y));
    trig_nxt.sz = sine_at(phase_of(word_in.angle_z));
    trig_nxt.cz = cosine_at(phase_of(word_in.angle_z));
  end

  // Load on advance, hold otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      trig_r <= trig_nxt;
    end
  end

  assign trig_out = trig_r;

endmodule

// ===== src/erm_prod.sv =====
`timescale 1ns / 1ps

module erm_prod (
  input  logic           clk,
  input  logic           en,
  input  erm_pkg::trig_t trig_in,
  output erm_pkg::prod_t prod_out
);

  erm_pkg::prod_t prod_nxt;
  erm_pkg::prod_t prod_r;

  // Form all first-level products in parallel; pass sx and cx, negate sy
  always_comb begin
    prod_nxt.sx   = trig_in.sx;
    prod_nxt.cx   = trig_in.cx;
    prod_nxt.szsy = erm_pkg::fmul(trig_in.sz, trig_in.sy);
    prod_nxt.czsy = erm_pkg::fmul(trig_in.cz, trig_in.sy);
    prod_nxt.czcy = erm_pkg::fmul(trig_in.cz, trig_in.cy);
    prod_nxt.szcy = erm_pkg::fmul(trig_in.sz, trig_in.cy);
    prod_nxt.sxcy = erm_pkg::fmul(trig_in.sx, trig_in.cy);
    prod_nxt.cxcy = erm_pkg::fmul(trig_in.cx, trig_in.cy);
    prod_nxt.sxsz = erm_pkg::fmul(trig_in.sx, trig_in.sz);
    prod_nxt.cxsz = erm_pkg::fmul(trig_in.cx, trig_in.sz);
    prod_nxt.cxcz = erm_pkg::fmul(trig_in.cx, trig_in.cz);
    prod_nxt.sxcz = erm_pkg::fmul(trig_in.sx, trig_in.cz);
    prod_nxt.nsy  = -trig_in.sy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_out = prod_r;

endmodule

// ===== src/erm_term.sv =====
`timescale 1ns / 1ps

module erm_term (
  input  logic           clk,
  input  logic           en,
  input  erm_pkg::prod_t prod_in,
  output erm_pkg::term_t term_out
);

  erm_pkg::term_t term_nxt;
  erm_pkg::term_t term_r;

  // Apply the X terms to the rounded Z*Y products; pass the rest
  always_comb begin
    term_nxt.czcy    = prod_in.czcy;
    term_nxt.szcy    = prod_in.szcy;
    term_nxt.nsy     = prod_in.nsy;
    term_nxt.sxcy    = prod_in.sxcy;
    term_nxt.cxcy    = prod_in.cxcy;
    term_nxt.sx_czsy = erm_pkg::fmul(prod_in.sx, prod_in.czsy);
    term_nxt.cxsz    = prod_in.cxsz;
    term_nxt.cx_czsy = erm_pkg::fmul(prod_in.cx, prod_in.czsy);
    term_nxt.sxsz    = prod_in.sxsz;
    term_nxt.sx_szsy = erm_pkg::fmul(prod_in.sx, prod_in.szsy);
    term_nxt.cxcz    = prod_in.cxcz;
    term_nxt.cx_szsy = erm_pkg::fmul(prod_in.cx, prod_in.szsy);
    term_nxt.sxcz    = prod_in.sxcz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= term_nxt;
    end
  end

  assign term_out = term_r;

endmodule

// ===== src/erm_sum.sv =====
`timescale 1ns / 1ps

module erm_sum (
  input  logic               clk,
  input  logic               en,
  input  erm_pkg::term_t     term_in,
  output erm_pkg::out_word_t word_out
);

  localparam int OW = erm_pkg::OUT_W;
  localparam int SW = erm_pkg::SUM_W;

  erm_pkg::out_word_t word_nxt;
  erm_pkg::out_word_t word_r;

  // Clamp a widened value to plus or minus one
  function automatic logic signed [OW-1:0] sat(logic signed [SW-1:0] v);
    logic signed [SW-1:0] lim;
    lim = SW'(erm_pkg::ONE_FX);
    if (v > lim) begin
      return erm_pkg::ONE_FX;
    end else if (v < -lim) begin
      return -erm_pkg::ONE_FX;
    end
    return v[OW-1:0];
  endfunction

  function automatic logic signed [OW-1:0] add_sat(logic signed [OW-1:0] a,
                                                   logic signed [OW-1:0] b);
    return sat(SW'(a) + SW'(b));
  endfunction

  function automatic logic signed [OW-1:0] sub_sat(logic signed [OW-1:0] a,
                                                   logic signed [OW-1:0] b);
    return sat(SW'(a) - SW'(b));
  endfunction

  // Combine terms into the nine entries
  always_comb begin
    word_nxt.m00 = sat(SW'(term_in.czcy));
    word_nxt.m01 = sub_sat(term_in.sx_czsy, term_in.cxsz);
    word_nxt.m02 = add_sat(term_in.cx_czsy, term_in.sxsz);
    word_nxt.m10 = sat(SW'(term_in.szcy));
    word_nxt.m11 = add_sat(term_in.sx_szsy, term_in.cxcz);
    word_nxt.m12 = sub_sat(term_in.cx_szsy, term_in.sxcz);
    word_nxt.m20 = sat(SW'(term_in.nsy));
    word_nxt.m21 = sat(SW'(term_in.sxcy));
    word_nxt.m22 = sat(SW'(term_in.cxcy));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign word_out = word_r;

endmodule

// ===== src/euler_rotation_matrix.sv =====
`timescale 1ns / 1ps

// Z*Y*X Euler rotation matrix: takes one word of three binary angles (65536 units
// per turn) and returns the nine entries of R = Rz*Ry*Rx in Q1.14, each saturated
// to plus or minus one. Four register stages (table lookup, first products, second
// products, sums), and out_valid is the valid bit of the sums stage; a new word is
// taken every cycle while the output side keeps out_stall low. Stages with no word
// in them close up under a stall, so in_stall rises only when all four stages are
// full and the output is stalled.
module euler_rotation_matrix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  erm_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output erm_pkg::out_word_t out_word
);

  localparam int NS = erm_pkg::STAGES;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] adv;

  erm_pkg::trig_t trig;
  erm_pkg::prod_t prod;
  erm_pkg::term_t term;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    adv[NS-1] = !v_r[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (adv[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int i = 1; i < NS; i++) begin
      if (adv[i]) begin
        v_nxt[i] = v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = v_r[NS-1];

  erm_trig u_trig (
    .clk      (clk),
    .en       (adv[0]),
    .word_in  (in_word),
    .trig_out (trig)
  );

  erm_prod u_prod (
    .clk      (clk),
    .en       (adv[1]),
    .trig_in  (trig),
    .prod_out (prod)
  );

  erm_term u_term (
    .clk      (clk),
    .en       (adv[2]),
    .prod_in  (prod),
    .term_out (term)
  );

  erm_sum u_sum (
    .clk      (clk),
    .en       (adv[3]),
    .term_in  (term),
    .word_out (out_word)
  );

  // Stall the input only when the whole pipe is full
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r) && out_stall)
    else $error("input stalled with a free stage");

  // Keep a held word in its stage
  a_hold_mid : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] && !adv[2] |=> v_r[1])
    else $error("word dropped from a held stage");

  // Keep entries m01 and m11 within plus or minus one
  a_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.m01 <= erm_pkg::ONE_FX) && (out_word.m01 >= -erm_pkg::ONE_FX)
                  && (out_word.m11 <= erm_pkg::ONE_FX) && (out_word.m11 >= -erm_pkg::ONE_FX))
    else $error("matrix entry out of range");

endmodule

// ===== tb/sv/euler_rotation_matrix_tb.sv =====
`timescale 1ns / 1ps

module euler_rotation_matrix_tb;
  import erm_pkg::*;

  localparam int IDX_W   = SINE_INDEX_BITS;
  localparam int QTR     = 1 << (IDX_W - 2);
  localparam int FB      = FRACTION_BITS;
  localparam int NFIELDS = 9;
  localparam int RANDOM_WORDS = 1100;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  // Predicts the rotation matrix for each accepted angle word and matches results in order
  class rotation_tracker;
    int        sin_quarter [0:QTR];
    out_word_t pending_mats[$];
    int        mismatches;

    // Build the quarter-wave sine table by the integer Taylor series in Q60
    function new();
      logic [63:0]  half_pi;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  acc;
      logic [63:0]  r;
      logic [127:0] p;
      half_pi = 64'h1921FB54442D1847;
      mismatches = 0;
      for (int k = 0; k <= QTR; k++) begin
        x = (half_pi / QTR) * 64'(k) + ((half_pi % QTR) * 64'(k)) / QTR;
        p = 128'(x) * 128'(x);
        x2 = 64'(p >> 60);
        term = x;
        acc = x;
        for (int i = 1; i <= 14; i++) begin
          p = 128'(term) * 128'(x2);
          term = 64'(p >> 60) / (64'(2 * i) * 64'(2 * i + 1));
          acc = (i % 2 == 1) ? acc - term : acc + term;
        end
        r = (acc + (64'd1 << (59 - FB))) >> (60 - FB);
        if (r > (64'd1 << FB)) r = 64'd1 << FB;
        sin_quarter[k] = int'(r);
      end
      sin_quarter[0] = 0;
      sin_quarter[QTR] = 1 << FB;
    endfunction

    function int pending();
      return pending_mats.size();
    endfunction

    // Reduce an angle to table phase; bits below the index are dropped
    function logic [IDX_W-1:0] phase_of(logic [IN_W-1:0] a);
      logic [ANGLE_BITS-1:0] t;
      t = a[ANGLE_BITS-1:0];
      return IDX_W'(t >> (ANGLE_BITS - IDX_W));
    endfunction

    // Fold the phase onto the quarter table by symmetry
    function longint sine_of(logic [IDX_W-1:0] idx);
      logic [1:0] quad;
      int         r;
      longint     v;
      quad = idx[IDX_W-1 -: 2];
      r = int'(idx[IDX_W-3:0]);
      v = quad[0] ? sin_quarter[QTR - r] : sin_quarter[r];
      return quad[1] ? -v : v;
    endfunction

    function longint cosine_of(logic [IDX_W-1:0] idx);
      return sine_of(IDX_W'(idx + QTR));
    endfunction

    // Product rounded half toward plus infinity
    function longint qmul(longint a, longint b);
      longint p;
      p = a * b + (longint'(1) <<< (FB - 1));
      return p >>> FB;
    endfunction

    function logic [OUT_W-1:0] pin_to_unit(longint v);
      longint lim;
      lim = longint'(1) <<< FB;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return OUT_W'(v);
    endfunction

    function out_word_t predict_matrix(in_word_t w);
      logic [IDX_W-1:0] ix;
      logic [IDX_W-1:0] iy;
      logic [IDX_W-1:0] iz;
      longint           sx, cx, sy, cy, sz, cz, szsy, czsy;
      out_word_t        m;
      ix = phase_of(w.angle_x);
      iy = phase_of(w.angle_y);
      iz = phase_of(w.angle_z);
      sx = sine_of(ix);
      cx = cosine_of(ix);
      sy = sine_of(iy);
      cy = cosine_of(iy);
      sz = sine_of(iz);
      cz = cosine_of(iz);
      szsy = qmul(sz, sy);
      czsy = qmul(cz, sy);
      m.m00 = pin_to_unit(qmul(cz, cy));
      m.m01 = pin_to_unit(qmul(sx, czsy) - qmul(cx, sz));
      m.m02 = pin_to_unit(qmul(cx, czsy) + qmul(sx, sz));
      m.m10 = pin_to_unit(qmul(sz, cy));
      m.m11 = pin_to_unit(qmul(sx, szsy) + qmul(cx, cz));
      m.m12 = pin_to_unit(qmul(cx, szsy) - qmul(sx, cz));
      m.m20 = pin_to_unit(-sy);
      m.m21 = pin_to_unit(qmul(sx, cy));
      m.m22 = pin_to_unit(qmul(cx, cy));
      return m;
    endfunction

    function void note_angles(in_word_t w);
      pending_mats.push_back(predict_matrix(w));
    endfunction

    // Compare a result word against the oldest prediction, entry by entry
    function void check_matrix(out_word_t got);
      string                    names [NFIELDS];
      logic [NFIELDS*OUT_W-1:0] exp_bits;
      logic [NFIELDS*OUT_W-1:0] got_bits;
      logic signed [OUT_W-1:0]  e;
      logic signed [OUT_W-1:0]  g;
      names = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
      if (pending_mats.size() == 0) begin
        $error("matrix word arrived with no angle word pending");
        mismatches++;
        return;
      end
      exp_bits = pending_mats.pop_front();
      got_bits = got;
      for (int i = 0; i < NFIELDS; i++) begin
        e = exp_bits[NFIELDS*OUT_W-1-OUT_W*i -: OUT_W];
        g = got_bits[NFIELDS*OUT_W-1-OUT_W*i -: OUT_W];
        if (e !== g) begin
          $error("%s: expected %0d, got %0d", names[i], e, g);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_word_t   in_word   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;

  rotation_tracker tracker;
  stall_mode_e     hold_mode = STALL_NONE;
  int              hold_left = 0;

  euler_rotation_matrix DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hold the run to a fixed budget
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stall the output side in stretches of changing character
  always @(posedge clk) begin
    if (hold_left == 0) begin
      hold_mode = stall_mode_e'($urandom_range(0, 3));
      hold_left = $urandom_range(16, 96);
    end
    hold_left--;
    case (hold_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:     out_stall <= ((hold_left % 8) < 3);
    endcase
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_matrix(out_word);
  end

  function automatic in_word_t angles(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    in_word_t w;
    w.angle_x = x;
    w.angle_y = y;
    w.angle_z = z;
    return w;
  endfunction

  // Mostly full-range angles, plus quadrant edges, tiny angles and exact table points
  function automatic in_word_t random_angles();
    int          pick;
    logic [15:0] a [3];
    pick = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      if (pick < 6) a[i] = 16'($urandom);
      else if (pick < 8) a[i] = 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 256) - 128);
      else if (pick < 9) a[i] = 16'($urandom_range(0, 600) - 300);
      else a[i] = 16'($urandom_range(0, 1023) << 6);
    end
    return angles(a[0], a[1], a[2]);
  endfunction

  // Present one word and hold it until taken
  task automatic send_word(input in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    tracker.note_angles(w);
  endtask

  // Drop valid for a gap, with junk on the bus
  task automatic idle_for(input int n);
    in_valid <= 1'b0;
    in_word  <= random_angles();
    repeat (n) @(posedge clk);
  endtask

  initial begin
    int burst_left;
    tracker = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corners: zero, extremes, right angles, half turn, ignored low bits
    send_word(angles(16'h0000, 16'h0000, 16'h0000));
    send_word(angles(16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_word(angles(16'h8000, 16'h8000, 16'h8000));
    send_word(angles(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(angles(16'h4000, 16'h0000, 16'h0000));
    send_word(angles(16'h0000, 16'h4000, 16'h0000));
    send_word(angles(16'h0000, 16'h0000, 16'h4000));
    send_word(angles(16'hC000, 16'hC000, 16'hC000));
    send_word(angles(16'h2000, 16'h2000, 16'h2000));
    send_word(angles(16'h003F, 16'h003F, 16'h003F));
    send_word(angles(16'h0040, 16'h0040, 16'h0040));
    send_word(angles(16'h3FC0, 16'h7FC0, 16'hBFC0));
    send_word(angles(16'h2000, 16'hE000, 16'h6000));
    send_word(angles(16'h1555, 16'h2AAA, 16'h5555));
    send_word(angles(16'h7FFF, 16'h0000, 16'h8000));
    send_word(angles(16'hAAAA, 16'h5555, 16'hAAAA));
    send_word(angles(16'h6000, 16'hA000, 16'h2000));
    send_word(angles(16'hE000, 16'h2000, 16'hA000));
    send_word(angles(16'h0000, 16'h8000, 16'h4000));
    send_word(angles(16'h1000, 16'h3000, 16'h5000));

    // Random words in bursts with random gaps
    burst_left = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
      end
      send_word(random_angles());
      burst_left--;
    end
    in_valid <= 1'b0;

    // Drain, then give stray words time to show up
    while (tracker.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
